/* rtl/rc4v_pkg.sv */
// rc4v_pkg: widths, codes and control word layout for the rc4 variant cipher
// used by the sequencer, the datapath and the top level; no dependencies
package rc4v_pkg;

  localparam int BYTE_W              = 8;
  localparam int SBOX_DEPTH          = 256;
  localparam int SBOX_AW             = 8;
  localparam int KEY_STORE_DEPTH_DEF = 256;
  localparam int UPC_W               = 4;

  localparam logic [BYTE_W-1:0] KEY_LENGTH_RST = 8'd1;
  localparam logic [BYTE_W-1:0] BYTE_MAX       = 8'hFF;

  // command codes of the func field
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_SCHED  = 2'd1,
    FUNC_CIPHER = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // s-box read address source
  typedef enum logic [2:0] {
    RA_I      = 3'd0,
    RA_I_NEXT = 3'd1,
    RA_J_NEW  = 3'd2,
    RA_SUM    = 3'd3,
    RA_IDX    = 3'd4
  } raddr_sel_t;

  typedef enum logic {
    WA_I = 1'b0,
    WA_J = 1'b1
  } waddr_sel_t;

  typedef enum logic [1:0] {
    WD_FILL = 2'd0,
    WD_RD   = 2'd1,
    WD_T    = 2'd2
  } wdata_sel_t;

  typedef enum logic [1:0] {
    JC_NEXT     = 2'd0,
    JC_ALWAYS   = 2'd1,
    JC_LOOP_I   = 2'd2,
    JC_DISPATCH = 2'd3
  } jump_t;

  typedef struct packed {
    raddr_sel_t       raddr_sel;
    logic             sbox_we;
    waddr_sel_t       waddr_sel;
    wdata_sel_t       wdata_sel;
    logic             i_inc;
    logic             ld_j;
    logic             add_key;
    logic             ld_t;
    logic             ld_u;
    logic             clr_idx;
    logic             pos_inc;
    logic             emit;
    jump_t            jump;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic i_last;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/rc4v_if.sv */
// rc4v_in_if / rc4v_out_if: valid-ready channels of the rc4 variant cipher
// no dependencies
interface rc4v_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key_index;
  logic [7:0] key_value;
  logic [7:0] data_byte;

  modport source(output valid, func, key_index, key_value, data_byte, input ready);
  modport sink(input valid, func, key_index, key_value, data_byte, output ready);
endinterface

interface rc4v_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source(output valid, out_byte, input ready);
  modport sink(input valid, out_byte, output ready);
endinterface

/* rtl/rc4v_ram.sv */
// rc4v_ram: generic single write port memory with one registered read port
// no dependencies
module rc4v_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rc4v_useq.sv */
// rc4v_useq: microcode store, step counter and jump logic of the cipher
// depends on rc4v_pkg
module rc4v_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_func,
  input  rc4v_pkg::stat_t stat,
  output logic            in_ready,
  output rc4v_pkg::ctrl_t ctrl
);
  import rc4v_pkg::*;

  localparam logic [UPC_W-1:0] UP_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] UP_RFILL = 4'd1;
  localparam logic [UPC_W-1:0] UP_RDONE = 4'd2;
  localparam logic [UPC_W-1:0] UP_SCHED = 4'd3;
  localparam logic [UPC_W-1:0] UP_SFILL = 4'd4;
  localparam logic [UPC_W-1:0] UP_S0    = 4'd5;
  localparam logic [UPC_W-1:0] UP_S1    = 4'd6;
  localparam logic [UPC_W-1:0] UP_S2    = 4'd7;
  localparam logic [UPC_W-1:0] UP_S3    = 4'd8;
  localparam logic [UPC_W-1:0] UP_SEND  = 4'd9;
  localparam logic [UPC_W-1:0] UP_C0    = 4'd10;
  localparam logic [UPC_W-1:0] UP_C1    = 4'd11;
  localparam logic [UPC_W-1:0] UP_C2    = 4'd12;
  localparam logic [UPC_W-1:0] UP_C3    = 4'd13;

  function automatic ctrl_t rom(input logic [UPC_W-1:0] a);
    ctrl_t w;
    w = '{raddr_sel: RA_I, waddr_sel: WA_I, wdata_sel: WD_FILL, jump: JC_NEXT,
          target: UP_IDLE, default: 1'b0};
    unique case (a)
      UP_IDLE: begin
        w.jump = JC_DISPATCH;
      end
      UP_RFILL, UP_SFILL: begin
        w.sbox_we = 1'b1;
        w.i_inc   = 1'b1;
        w.jump    = JC_LOOP_I;
        w.target  = a;
      end
      UP_RDONE: begin
        w.jump = JC_ALWAYS;
      end
      UP_SCHED: begin
        w.clr_idx = 1'b1;
      end
      UP_S0: begin
        w.raddr_sel = RA_I;
      end
      UP_S1: begin
        // acc lives in j during the schedule
        w.ld_j      = 1'b1;
        w.add_key   = 1'b1;
        w.ld_t      = 1'b1;
        w.raddr_sel = RA_J_NEW;
      end
      UP_S2: begin
        w.sbox_we   = 1'b1;
        w.wdata_sel = WD_RD;
      end
      UP_S3: begin
        w.sbox_we   = 1'b1;
        w.waddr_sel = WA_J;
        w.wdata_sel = WD_T;
        w.i_inc     = 1'b1;
        w.pos_inc   = 1'b1;
        w.jump      = JC_LOOP_I;
        w.target    = UP_S0;
      end
      UP_SEND: begin
        w.clr_idx = 1'b1;
        w.jump    = JC_ALWAYS;
      end
      UP_C0: begin
        w.i_inc     = 1'b1;
        w.raddr_sel = RA_I_NEXT;
      end
      UP_C1: begin
        w.ld_t      = 1'b1;
        w.ld_j      = 1'b1;
        w.raddr_sel = RA_J_NEW;
      end
      UP_C2: begin
        w.ld_u      = 1'b1;
        w.sbox_we   = 1'b1;
        w.wdata_sel = WD_RD;
        w.raddr_sel = RA_SUM;
      end
      UP_C3: begin
        w.emit      = 1'b1;
        w.sbox_we   = 1'b1;
        w.waddr_sel = WA_J;
        w.wdata_sel = WD_T;
        w.raddr_sel = RA_IDX;
        w.jump      = JC_ALWAYS;
      end
      default: begin
        w.jump = JC_ALWAYS;
      end
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_r, upc_nxt;
  ctrl_t            word;
  logic             stall;
  logic             accept;

  assign word     = rom(upc_r);
  assign in_ready = (upc_r == UP_IDLE);
  assign accept   = in_valid && in_ready;
  // the result step waits while the output register is still full
  assign stall    = word.emit && stat.out_busy;

  always_comb begin
    ctrl = word;
    if (stall) begin
      ctrl.sbox_we = 1'b0;
      ctrl.emit    = 1'b0;
    end
  end

  always_comb begin
    upc_nxt = upc_r + 1'b1;
    case (word.jump)
      JC_NEXT:   upc_nxt = upc_r + 1'b1;
      JC_ALWAYS: upc_nxt = word.target;
      JC_LOOP_I: upc_nxt = stat.i_last ? upc_r + 1'b1 : word.target;
      JC_DISPATCH: begin
        upc_nxt = UP_IDLE;
        if (accept) begin
          case (in_func)
            FUNC_SCHED:  upc_nxt = UP_SCHED;
            FUNC_CIPHER: upc_nxt = UP_C0;
            default:     upc_nxt = UP_IDLE;
          endcase
        end
      end
      default: upc_nxt = UP_IDLE;
    endcase
    if (stall) begin
      upc_nxt = upc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UP_RFILL;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* rtl/rc4v_dpath.sv */
// rc4v_dpath: s-box and key store memories, index registers and result register
// depends on rc4v_pkg and rc4v_ram
module rc4v_dpath #(
  parameter int KEY_STORE_DEPTH = rc4v_pkg::KEY_STORE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rc4v_pkg::ctrl_t ctrl,
  output rc4v_pkg::stat_t stat,
  input  logic            in_accept,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_key_index,
  input  logic [7:0]      in_key_value,
  input  logic [7:0]      in_data_byte,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [7:0]      out_byte
);
  import rc4v_pkg::*;

  localparam int KAW = $clog2(KEY_STORE_DEPTH);

  logic [BYTE_W-1:0]  i_r, i_nxt, j_r, j_nxt, pos_r, pos_nxt, pos_inc;
  logic [BYTE_W-1:0]  t_r, u_r, idx_r, data_r, key_length_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               krng_r;

  logic [BYTE_W-1:0]  srd, krd, kb, j_new, sum, ks;
  logic [SBOX_AW-1:0] s_raddr, s_waddr;
  logic [BYTE_W-1:0]  s_wdata;
  logic               k_we;

  assign kb    = krng_r ? krd : '0;
  assign j_new = j_r + srd + (ctrl.add_key ? kb : '0);
  assign sum   = t_r + srd;

  always_comb begin
    case (ctrl.raddr_sel)
      RA_I:      s_raddr = i_r;
      RA_I_NEXT: s_raddr = i_r + 1'b1;
      RA_J_NEW:  s_raddr = j_new;
      RA_SUM:    s_raddr = sum;
      RA_IDX:    s_raddr = idx_r;
      default:   s_raddr = i_r;
    endcase
  end

  assign s_waddr = (ctrl.waddr_sel == WA_J) ? j_r : i_r;

  always_comb begin
    case (ctrl.wdata_sel)
      WD_FILL: s_wdata = ~i_r;   // 255 minus index
      WD_RD:   s_wdata = srd;
      WD_T:    s_wdata = t_r;
      default: s_wdata = srd;
    endcase
  end

  rc4v_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
    .clk   (clk),
    .we    (ctrl.sbox_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (srd)
  );

  assign k_we = in_accept && (in_func == FUNC_LOAD) &&
                ({1'b0, in_key_index} < 9'(KEY_STORE_DEPTH));

  rc4v_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_STORE_DEPTH)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (in_key_index[KAW-1:0]),
    .wdata (in_key_value),
    .raddr (pos_r[KAW-1:0]),
    .rdata (krd)
  );

  // key byte after the swap: the pending writes to i and j are bypassed
  always_comb begin
    if (idx_r == j_r) begin
      ks = t_r;
    end else if (idx_r == i_r) begin
      ks = u_r;
    end else begin
      ks = srd;
    end
  end

  assign pos_inc = pos_r + 1'b1;

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    pos_nxt = pos_r;
    if (ctrl.i_inc) begin
      i_nxt = i_r + 1'b1;
    end
    if (ctrl.ld_j) begin
      j_nxt = j_new;
    end
    if (ctrl.pos_inc) begin
      pos_nxt = (pos_inc == key_length_r) ? '0 : pos_inc;
    end
    if (ctrl.clr_idx) begin
      i_nxt   = '0;
      j_nxt   = '0;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r          <= '0;
      j_r          <= '0;
      pos_r        <= '0;
      key_length_r <= KEY_LENGTH_RST;
      out_valid_r  <= 1'b0;
    end else begin
      i_r   <= i_nxt;
      j_r   <= j_nxt;
      pos_r <= pos_nxt;
      if (cfg_we) begin
        key_length_r <= cfg_wdata;
      end
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    krng_r <= ({1'b0, pos_r} < 9'(KEY_STORE_DEPTH));
    if (ctrl.ld_t) begin
      t_r <= srd;
    end
    if (ctrl.ld_u) begin
      u_r   <= srd;
      idx_r <= sum;
    end
    if (in_accept) begin
      data_r <= in_data_byte;
    end
    if (ctrl.emit) begin
      out_byte_r <= data_r ^ ks;
    end
  end

  assign stat.i_last   = (i_r == BYTE_MAX);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;

endmodule

/* rtl/rc4_variant_stream_cipher.sv */
// rc4_variant_stream_cipher: top level of the rc4 variant stream cipher
// depends on rc4v_pkg, rc4v_if, rc4v_useq and rc4v_dpath
//
// Byte-wide rc4-style cipher whose s-box starts as 255 minus index. Each input
// transaction carries a command: load one key byte (written as it is taken, no
// result), run the key schedule (no result) or cipher one data byte (one result).
// Input is taken only while the microcode sequencer sits at its idle step; all
// s-box work goes through one single-port-write memory with a registered read,
// so a cipher command occupies the idle step that takes it and 4 microcode steps,
// the last of which waits while the result register is still full, and a schedule
// command occupies the idle step, one clear step, a refill of all 256 s-box
// entries, 256 key steps of 4 microcode steps each and a closing clear step.
// After reset the block fills the s-box and passes a done step before it takes
// its first transaction. key_length is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce it.
// Length 0 gives a key period of 256. Unloaded key store entries read back undefined.
module rc4_variant_stream_cipher #(
  parameter int KEY_STORE_DEPTH = rc4v_pkg::KEY_STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rc4v_in_if.sink                in_ch,
  rc4v_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata
);
  import rc4v_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;
  logic  in_accept;

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  rc4v_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  rc4v_dpath #(.KEY_STORE_DEPTH(KEY_STORE_DEPTH)) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .stat         (stat),
    .in_accept    (in_accept),
    .in_func      (in_ch.func),
    .in_key_index (in_ch.key_index),
    .in_key_value (in_ch.key_value),
    .in_data_byte (in_ch.data_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.out_byte)
  );

endmodule

/* test/rc4_variant_stream_cipher_tb.sv */
// rc4_variant_stream_cipher_tb: self-checking bench for the rc4 variant stream cipher
// directed table, then random key/schedule/cipher sequences under several stall patterns
// depends on rc4v_pkg, rc4v_if and rc4_variant_stream_cipher
module rc4_variant_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4v_pkg::*;

  localparam int SETTLE_CYCLES = 1300;   // long enough for a schedule command to finish
  localparam int QUIET_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 85;
  localparam int DIR_ROWS      = 24;

  typedef struct packed {
    func_t      func;
    logic [7:0] key_index;
    logic [7:0] key_value;
    logic [7:0] data_byte;
    logic       has_want;
    logic [7:0] want;
  } cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  rc4v_in_if  in_ch();
  rc4v_out_if out_ch();

  rc4_variant_stream_cipher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // cipher state as the block should hold it
  logic [7:0] sbox_m [256];
  logic [7:0] key_mem [256];
  bit         key_loaded [256];
  logic [7:0] idx_i;
  logic [7:0] idx_j;
  logic [7:0] key_len;

  logic [7:0] out_bytes_due [$];
  logic [7:0] want_byte;
  int         errors;
  int         item_count;
  int         quiet;
  int         send_idle_pct;
  int         stall_pct;
  int         hold_left;
  bit         hold_req;
  cmd_t       dir_rows [DIR_ROWS];

  function automatic void refill_sbox();
    for (int k = 0; k < 256; k++) sbox_m[k] = 8'(255 - k);
  endfunction

  function automatic void run_key_schedule();
    logic [7:0] acc;
    logic [7:0] pos;
    logic [7:0] t;
    acc = 8'd0;
    pos = 8'd0;
    refill_sbox();
    for (int step = 0; step < 256; step++) begin
      acc = acc + sbox_m[step] + key_mem[pos];
      t = sbox_m[step];
      sbox_m[step] = sbox_m[acc];
      sbox_m[acc] = t;
      pos = pos + 8'd1;
      // length zero never matches, so the position wraps at 256
      if (pos == key_len) pos = 8'd0;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
  endfunction

  function automatic logic [7:0] next_keystream_byte();
    logic [7:0] t;
    logic [7:0] sum;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox_m[idx_i];
    t = sbox_m[idx_i];
    sbox_m[idx_i] = sbox_m[idx_j];
    sbox_m[idx_j] = t;
    sum = sbox_m[idx_i] + sbox_m[idx_j];
    return sbox_m[sum];
  endfunction

  // advances the state by one command; returns 1 when it yields an output byte
  function automatic bit apply_command(input cmd_t c, output logic [7:0] res);
    res = 8'd0;
    case (c.func)
      FUNC_LOAD: begin
        key_mem[c.key_index] = c.key_value;
        key_loaded[c.key_index] = 1'b1;
      end
      FUNC_SCHED: run_key_schedule();
      FUNC_CIPHER: begin
        res = c.data_byte ^ next_keystream_byte();
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int key_period();
    return (key_len == 8'd0) ? 256 : int'(key_len);
  endfunction

  function automatic bit keys_ready();
    for (int k = 0; k < key_period(); k++)
      if (!key_loaded[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic cmd_t make_cmd(func_t f, logic [7:0] k, logic [7:0] v, logic [7:0] d);
    cmd_t c;
    c.func = f;
    c.key_index = k;
    c.key_value = v;
    c.data_byte = d;
    c.has_want = 1'b0;
    c.want = 8'd0;
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    logic [7:0] res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= c.func;
    in_ch.key_index <= c.key_index;
    in_ch.key_value <= c.key_value;
    in_ch.data_byte <= c.data_byte;
    do @(posedge clk); while (!in_ch.ready);
    if (apply_command(c, res)) out_bytes_due.push_back(c.has_want ? c.want : res);
    if (c.func != FUNC_NONE) item_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (out_bytes_due.size() != 0);
  endtask

  task automatic write_key_length(input logic [7:0] len);
    drain_results();
    // loads and schedules give no result, so let the last of them finish
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we  <= 1'b0;
    key_len = len;
  endtask

  task automatic send_ciphers(input int n);
    repeat (n) send_cmd(make_cmd(FUNC_CIPHER, 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic rekey();
    int period;
    period = key_period();
    if (period <= 24) begin
      for (int k = 0; k < period; k++)
        send_cmd(make_cmd(FUNC_LOAD, 8'(k), 8'($urandom), 8'($urandom)));
    end else begin
      for (int k = 0; k < period; k++)
        if (!key_loaded[k]) send_cmd(make_cmd(FUNC_LOAD, 8'(k), 8'($urandom), 8'($urandom)));
      repeat (8)
        send_cmd(make_cmd(FUNC_LOAD, 8'($urandom_range(0, period - 1)), 8'($urandom),
                          8'($urandom)));
    end
  endtask

  task automatic run_phase(input int ph, input int target);
    int pick;
    int seq_n;
    seq_n = 0;
    while (item_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        if ($urandom_range(0, 1) == 0)
          send_cmd(make_cmd(FUNC_NONE, 8'($urandom), 8'($urandom), 8'($urandom)));
        else
          send_cmd(make_cmd(FUNC_LOAD, 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (pick < 18) begin
        // schedule with stale key, or keystream carried on without a new schedule
        if (keys_ready() && $urandom_range(0, 1) == 0)
          send_cmd(make_cmd(FUNC_SCHED, 8'($urandom), 8'($urandom), 8'($urandom)));
        else
          send_ciphers($urandom_range(1, 6));
      end else begin
        rekey();
        send_cmd(make_cmd(FUNC_SCHED, 8'($urandom), 8'($urandom), 8'($urandom)));
        if (seq_n == 0 && ph == 4) hold_req = 1'b1;
        if (seq_n == 0 && ph == 5) drain_results();
        send_ciphers($urandom_range(3, 24));
        seq_n++;
      end
    end
  endtask

  // result side: stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_bytes_due.size() == 0) begin
        $error("out_byte expected none actual %02h", out_ch.out_byte);
        errors++;
      end else begin
        want_byte = out_bytes_due.pop_front();
        if (out_ch.out_byte !== want_byte) begin
          $error("out_byte expected %02h actual %02h", want_byte, out_ch.out_byte);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("rc4_variant_stream_cipher_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] lens [PHASES];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'd0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_NONE;
    in_ch.key_index = 8'd0;
    in_ch.key_value = 8'd0;
    in_ch.data_byte = 8'd0;
    out_ch.ready    = 1'b0;
    errors          = 0;
    item_count      = 0;
    quiet           = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_left       = 0;
    hold_req        = 1'b0;
    refill_sbox();
    for (int k = 0; k < 256; k++) begin
      key_mem[k] = 8'd0;
      key_loaded[k] = 1'b0;
    end
    idx_i   = 8'd0;
    idx_j   = 8'd0;
    key_len = KEY_LENGTH_RST;

    // first cipher after reset: i=1, j=254, swap leaves s[1]=1, s[254]=254, reads s[255]=0
    dir_rows = '{
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'hA5, 1'b1, 8'hA5},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_NONE,   8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'h3C, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'h00, 8'hFF, 8'h00, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'hFE, 8'h80, 8'h00, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'h7F, 8'h01, 8'h00, 1'b0, 8'h00},
      '{FUNC_SCHED,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'h5A, 1'b0, 8'h00},
      '{FUNC_NONE,   8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_SCHED,  8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00},
      '{FUNC_SCHED,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'h00, 8'h80, 8'h00, 1'b0, 8'h00},
      '{FUNC_LOAD,   8'h01, 8'h7F, 8'h00, 1'b0, 8'h00},
      '{FUNC_SCHED,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
      '{FUNC_CIPHER, 8'h00, 8'h00, 8'hAA, 1'b0, 8'h00}
    };
    lens = '{8'd0, 8'd255, 8'd254, 8'd1, 8'($urandom_range(1, 24)), 8'd2,
             8'($urandom_range(1, 24)), 8'($urandom_range(1, 254))};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) send_cmd(dir_rows[r]);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      write_key_length(lens[ph]);
      run_phase(ph, item_count + PHASE_ITEMS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("rc4_variant_stream_cipher_tb: clean");
    else
      $display("rc4_variant_stream_cipher_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/rc4v_pkg.sv
rtl/rc4v_if.sv
rtl/rc4v_ram.sv
rtl/rc4v_useq.sv
rtl/rc4v_dpath.sv
rtl/rc4_variant_stream_cipher.sv
test/rc4_variant_stream_cipher_tb.sv
